/* hdl/acc8051_pkg.sv */
// Shared types, operation codes and the division step of the 8051 accumulator ALU.
package acc8051_pkg;

    // Number of register stages in the datapath and radix-2 steps done in each.
    localparam int unsigned STAGES          = 4;
    localparam int unsigned DATA_W          = 8;
    localparam int unsigned STEPS_PER_STAGE = DATA_W / STAGES;

    // Operation codes carried on the kind field.
    typedef enum logic [3:0] {
        OP_RR    = 4'd0,
        OP_RRC   = 4'd1,
        OP_RL    = 4'd2,
        OP_RLC   = 4'd3,
        OP_MUL   = 4'd4,
        OP_DIV   = 4'd5,
        OP_SWAP  = 4'd6,
        OP_DA    = 4'd7,
        OP_CLR_A = 4'd8,
        OP_CLR_C = 4'd9,
        OP_SETB_C = 4'd10,
        OP_CPL_C = 4'd11
    } op_kind_t;

    // Partial state of the restoring divider.
    typedef struct packed {
        logic [DATA_W-1:0] rem;
        logic [DATA_W-1:0] quo;
        logic [DATA_W-1:0] dvs;
    } div_t;

    // Contents of one pipeline stage.
    typedef struct packed {
        logic [DATA_W-1:0] res_acc;
        logic [DATA_W-1:0] res_breg;
        logic              res_cy;
        logic              res_ov;
        logic              div_ok;
        div_t              dv;
    } stage_t;

    // One restoring division step: the next dividend bit moves into the
    // remainder and one quotient bit is shifted in at the bottom.
    function automatic div_t div_step(input div_t d);
        div_t              r;
        logic [DATA_W+1:0] diff;
        diff = {1'b0, d.rem, d.quo[DATA_W-1]} - {2'b00, d.dvs};
        r.dvs = d.dvs;
        if (!diff[DATA_W+1])
        begin
            r.rem = diff[DATA_W-1:0];
            r.quo = {d.quo[DATA_W-2:0], 1'b1};
        end
        else
        begin
            r.rem = {d.rem[DATA_W-2:0], d.quo[DATA_W-1]};
            r.quo = {d.quo[DATA_W-2:0], 1'b0};
        end
        return r;
    endfunction

    // The share of the division that one stage performs.
    function automatic div_t div_stage(input div_t d);
        div_t r;
        r = d;
        for (int unsigned i = 0; i < STEPS_PER_STAGE; i++)
        begin
            r = div_step(r);
        end
        return r;
    endfunction

endpackage

/* hdl/accumulator_alu_8051.sv */
// Top level of the pipelined 8051 accumulator ALU.
//
//  Channel  | Handshake             | Payload
//  ---------+-----------------------+-----------------------------------------------
//  input    | in_valid / in_ready   | kind, acc_in, breg_in, carry_in, aux_carry_in,
//           |                       | overflow_in
//  output   | out_valid / out_ready | acc_out, breg_out, carry_out, overflow_out
//
// A beat is accepted into the pipeline in every cycle in which in_valid and in_ready are
// both high, so the block sustains one operation per clock while out_ready stays high. A
// beat passes through the stage registers in order before it shows on the output; the
// pipeline depth is set by the divider, which resolves two quotient bits in each of the
// four stages. Every stage has its own valid bit and advances when it is empty or
// its successor advances, so a stall on out_ready holds all data in place and empty
// stages still fill behind it. The asynchronous reset (rst_n, active low) clears only
// the valid bits; the payload registers need no reset.
module accumulator_alu_8051 (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [3:0]                     kind,
    input  logic [acc8051_pkg::DATA_W-1:0] acc_in,
    input  logic [acc8051_pkg::DATA_W-1:0] breg_in,
    input  logic                           carry_in,
    input  logic                           aux_carry_in,
    input  logic                           overflow_in,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [acc8051_pkg::DATA_W-1:0] acc_out,
    output logic [acc8051_pkg::DATA_W-1:0] breg_out,
    output logic                           carry_out,
    output logic                           overflow_out
);
    import acc8051_pkg::*;

    // Pipeline registers, one entry per stage, and their next values.
    logic   [STAGES-1:0] valid_reg;
    stage_t              pipe_reg  [STAGES];
    stage_t              pipe_next [STAGES];
    stage_t              head_next;
    logic   [STAGES-1:0] en;

    // Intermediate values of the first stage's operation decode.
    logic [2*DATA_W-1:0] prod;
    logic                da_lo_adj;
    logic                da_hi_adj;
    logic [DATA_W:0]     da_sum1;
    logic [DATA_W:0]     da_sum2;
    logic                da_cy1;
    div_t                div_init;

    // A stage may load when it is empty or when its contents move on this cycle.
    always_comb
    begin
        en[STAGES-1] = !valid_reg[STAGES-1] || out_ready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    assign in_ready = en[0];

    // First stage: every operation except the division completes here. The division
    // starts here, with its flags and the divide-by-zero outcome already in place.
    always_comb
    begin
        prod      = {{DATA_W{1'b0}}, acc_in} * {{DATA_W{1'b0}}, breg_in};
        da_lo_adj = (acc_in[3:0] > 4'd9) || aux_carry_in;
        da_sum1   = {1'b0, acc_in} + (da_lo_adj ? 9'h006 : 9'h000);
        da_cy1    = carry_in || da_sum1[DATA_W];
        da_hi_adj = (da_sum1[7:4] > 4'd9) || da_cy1;
        da_sum2   = {1'b0, da_sum1[DATA_W-1:0]} + (da_hi_adj ? 9'h060 : 9'h000);

        div_init.rem = '0;
        div_init.quo = acc_in;
        div_init.dvs = breg_in;

        head_next.res_acc  = acc_in;
        head_next.res_breg = breg_in;
        head_next.res_cy   = carry_in;
        head_next.res_ov   = overflow_in;
        head_next.div_ok   = 1'b0;
        head_next.dv       = div_stage(div_init);

        unique case (kind)
            OP_RR:
            begin
                head_next.res_acc = {acc_in[0], acc_in[DATA_W-1:1]};
            end
            OP_RRC:
            begin
                head_next.res_acc = {carry_in, acc_in[DATA_W-1:1]};
                head_next.res_cy  = acc_in[0];
            end
            OP_RL:
            begin
                head_next.res_acc = {acc_in[DATA_W-2:0], acc_in[DATA_W-1]};
            end
            OP_RLC:
            begin
                head_next.res_acc = {acc_in[DATA_W-2:0], carry_in};
                head_next.res_cy  = acc_in[DATA_W-1];
            end
            OP_MUL:
            begin
                head_next.res_acc  = prod[DATA_W-1:0];
                head_next.res_breg = prod[2*DATA_W-1:DATA_W];
                head_next.res_cy   = 1'b0;
                head_next.res_ov   = |prod[2*DATA_W-1:DATA_W];
            end
            OP_DIV:
            begin
                // On a zero divisor A and B pass through unchanged and OV is set.
                head_next.res_cy = 1'b0;
                head_next.res_ov = (breg_in == '0);
                head_next.div_ok = (breg_in != '0);
            end
            OP_SWAP:
            begin
                head_next.res_acc = {acc_in[3:0], acc_in[7:4]};
            end
            OP_DA:
            begin
                // The carry is only ever set by the decimal adjust, never cleared.
                head_next.res_acc = da_sum2[DATA_W-1:0];
                head_next.res_cy  = da_cy1 || da_sum2[DATA_W];
            end
            OP_CLR_A:
            begin
                head_next.res_acc = '0;
            end
            OP_CLR_C:
            begin
                head_next.res_cy = 1'b0;
            end
            OP_SETB_C:
            begin
                head_next.res_cy = 1'b1;
            end
            OP_CPL_C:
            begin
                head_next.res_cy = !carry_in;
            end
            default:
            begin
                // Unused codes leave every value as it came in.
                head_next.res_acc = acc_in;
            end
        endcase
    end

    // Later stages advance the division; the last one writes the quotient and
    // remainder over A and B when the division was valid.
    always_comb
    begin
        pipe_next[0] = head_next;
        for (int k = 1; k < STAGES; k++)
        begin
            pipe_next[k]    = pipe_reg[k-1];
            pipe_next[k].dv = div_stage(pipe_reg[k-1].dv);
        end
        if (pipe_reg[STAGES-2].div_ok)
        begin
            pipe_next[STAGES-1].res_acc  = pipe_next[STAGES-1].dv.quo;
            pipe_next[STAGES-1].res_breg = pipe_next[STAGES-1].dv.rem;
        end
    end

    // Valid bits are control state and are cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k < STAGES; k++)
            begin
                if (en[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // Payload registers load only when a valid beat moves in.
    always_ff @(posedge clk)
    begin
        if (en[0] && in_valid)
        begin
            pipe_reg[0] <= pipe_next[0];
        end
        for (int k = 1; k < STAGES; k++)
        begin
            if (en[k] && valid_reg[k-1])
            begin
                pipe_reg[k] <= pipe_next[k];
            end
        end
    end

    assign out_valid    = valid_reg[STAGES-1];
    assign acc_out      = pipe_reg[STAGES-1].res_acc;
    assign breg_out     = pipe_reg[STAGES-1].res_breg;
    assign carry_out    = pipe_reg[STAGES-1].res_cy;
    assign overflow_out = pipe_reg[STAGES-1].res_ov;

endmodule

/* hdl/acc8051_checker.sv */
// Port-level checks for the 8051 accumulator ALU, bound to the top level.
module acc8051_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic [3:0]                     kind,
    input logic [acc8051_pkg::DATA_W-1:0] acc_in,
    input logic [acc8051_pkg::DATA_W-1:0] breg_in,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [acc8051_pkg::DATA_W-1:0] acc_out,
    input logic [acc8051_pkg::DATA_W-1:0] breg_out,
    input logic                           carry_out,
    input logic                           overflow_out
);
    import acc8051_pkg::*;

    // A result that is not taken holds still.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(acc_out) && $stable(breg_out)
            && $stable(carry_out) && $stable(overflow_out))
        else $error("stalled result changed");

    // With nothing waiting at the output, the pipeline cannot refuse a beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked while output empty");

    // A cleared accumulator reaches the output when the output keeps draining.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && kind == OP_CLR_A && out_ready) ##1 out_ready
            ##1 out_ready ##1 out_ready |=> out_valid && acc_out == '0)
        else $error("clear of A not seen after pipeline latency");

    // A division by zero sets OV, clears CY and keeps A and B.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && kind == OP_DIV && breg_in == '0 && out_ready)
            ##1 out_ready ##1 out_ready ##1 out_ready
            |=> out_valid && overflow_out && !carry_out && breg_out == '0
                && acc_out == $past(acc_in, 4))
        else $error("divide by zero result wrong");

endmodule

bind accumulator_alu_8051 acc8051_checker u_acc8051_checker (.*);
